// ===== sv/tcws_pkg.sv =====
package tcws_pkg;

  // Default number of supervised tasks
  localparam int NUM_TASKS_DEF = 32;

  // Configuration register map (register index, byte address = 4 * index)
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_IDX_W   = CFG_ADDR_W - 2;
  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_MASK = CFG_IDX_W'(0);

  // Reset-reason bit that marks a watchdog reset
  localparam int WDT_REASON_BIT = 0;

  // Event kinds
  typedef enum logic [1:0] {
    CMD_CHECKIN = 2'd0,
    CMD_POLL    = 2'd1,
    CMD_BOOT    = 2'd2
  } cmd_t;

  // One input transaction
  typedef struct packed {
    logic [1:0]  cmd;
    logic [4:0]  task_id;
    logic [31:0] boot_cause;
  } in_item_t;

  // One result transaction
  typedef struct packed {
    logic        feed;
    logic [31:0] missing_tasks;
    logic [31:0] boot_total;
    logic [31:0] watchdog_resets;
    logic [31:0] stuck_tasks;
  } out_item_t;

endpackage

// ===== sv/tcws_stream_if.sv =====
interface tcws_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/task_checkin_watchdog_supervisor.sv =====
// Multi-task check-in watchdog supervisor with a boot record.
//
// Input channel in_ch carries one event per transaction: cmd (0 task check-in,
// 1 supervisor poll, 2 boot with reset reason), task_id and boot_cause.
// Output channel out_ch returns exactly one result transaction per event:
// feed, missing_tasks, boot_total, watchdog_resets and stuck_tasks, all taken
// after the event has been applied.
// The APB port holds expected_mask at byte address 0; write it only while the
// block is idle. pready is tied high.
//
// An accepted event is held in the input register, is processed into the result
// register, and its result is offered on out_ch from there.
// Throughput: one event per cycle while out_ch takes results; the state update is a
// single mask or counter step between the input register and the result register.
// Reset (rst_n low, synchronous) clears the check-in mask, the record valid
// flag, both counters, the missing and stuck masks and expected_mask.
// When out_ch stalls, the result register holds and the input register
// still takes one more event; in_ch.ready drops only when both are full.
module task_checkin_watchdog_supervisor
  import tcws_pkg::*;
#(
  parameter int NUM_TASKS = NUM_TASKS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  tcws_stream_if.sink           in_ch,
  tcws_stream_if.source         out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic        in_valid_r;
  in_item_t    in_item_r;
  logic        out_valid_r;
  out_item_t   out_item_r;
  logic        out_free;
  logic        step;
  logic        in_take;
  logic [31:0] expected_mask;
  out_item_t   res;

  tcws_cfg u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (cfg_psel),
    .penable       (cfg_penable),
    .pwrite        (cfg_pwrite),
    .paddr         (cfg_paddr),
    .pwdata        (cfg_pwdata),
    .prdata        (cfg_prdata),
    .pready        (cfg_pready),
    .expected_mask (expected_mask)
  );

  tcws_core #(
    .NUM_TASKS (NUM_TASKS)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step_en       (step),
    .item          (in_item_r),
    .expected_mask (expected_mask),
    .res           (res)
  );

  // Handshake control
  assign out_free    = !out_valid_r || out_ch.ready;
  assign step        = in_valid_r && out_free;
  assign in_ch.ready = !in_valid_r || step;
  assign in_take     = in_ch.valid && in_ch.ready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_ch.payload;
    end
  end

  // Result register: load on a processed transaction, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_item_r <= res;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_item_r;

endmodule

// ===== sv/tcws_cfg.sv =====
module tcws_cfg
  import tcws_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [31:0]           expected_mask
);

  logic [31:0]          expected_mask_r;
  logic                 wr_en;
  logic [CFG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  // Hold the expected-task mask; take it on a completed write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_mask_r <= '0;
    end else if (wr_en && (reg_idx == REG_EXPECTED_MASK)) begin
      expected_mask_r <= pwdata[31:0];
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    if (reg_idx == REG_EXPECTED_MASK) begin
      prdata = CFG_DATA_W'(expected_mask_r);
    end
  end

  assign expected_mask = expected_mask_r;

endmodule

// ===== sv/tcws_core.sv =====
module tcws_core
  import tcws_pkg::*;
#(
  parameter int NUM_TASKS = NUM_TASKS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step_en,
  input  in_item_t    item,
  input  logic [31:0] expected_mask,
  output out_item_t   res
);

  localparam logic [NUM_TASKS-1:0] TASK_BIT0 = NUM_TASKS'(1);

  logic [NUM_TASKS-1:0] checkin_mask_r, checkin_mask_nxt;
  logic                 record_valid_r, record_valid_nxt;
  logic [31:0]          boot_count_r, boot_count_nxt;
  logic [31:0]          wdt_count_r, wdt_count_nxt;
  logic [31:0]          last_missing_r, last_missing_nxt;
  logic [31:0]          stuck_mask_r, stuck_mask_nxt;
  logic                 feed;
  logic [31:0]          checkin_wide;
  logic [31:0]          missing;
  logic                 task_in_range;
  logic                 wdt_boot;
  logic [31:0]          base_boot, base_wdt, base_missing, base_stuck;

  assign checkin_wide  = 32'(checkin_mask_r);
  assign missing       = expected_mask & ~checkin_wide;
  assign task_in_range = ({1'b0, item.task_id} < 6'(NUM_TASKS));
  assign wdt_boot      = item.boot_cause[WDT_REASON_BIT];

  // A boot on an invalid record starts from a cleared record
  assign base_boot    = record_valid_r ? boot_count_r   : '0;
  assign base_wdt     = record_valid_r ? wdt_count_r    : '0;
  assign base_missing = record_valid_r ? last_missing_r : '0;
  assign base_stuck   = record_valid_r ? stuck_mask_r   : '0;

  // Work out the state after this event
  always_comb begin
    checkin_mask_nxt = checkin_mask_r;
    record_valid_nxt = record_valid_r;
    boot_count_nxt   = boot_count_r;
    wdt_count_nxt    = wdt_count_r;
    last_missing_nxt = last_missing_r;
    stuck_mask_nxt   = stuck_mask_r;
    feed             = 1'b0;
    case (cmd_t'(item.cmd))
      CMD_CHECKIN: begin
        if (task_in_range) begin
          checkin_mask_nxt = checkin_mask_r | (TASK_BIT0 << item.task_id);
        end
      end
      CMD_POLL: begin
        last_missing_nxt = missing;
        if (missing == '0) begin
          checkin_mask_nxt = '0;
          feed             = 1'b1;
        end
      end
      CMD_BOOT: begin
        record_valid_nxt = 1'b1;
        boot_count_nxt   = base_boot + 32'd1;
        wdt_count_nxt    = base_wdt + 32'(wdt_boot);
        last_missing_nxt = base_missing;
        stuck_mask_nxt   = wdt_boot ? base_missing : base_stuck;
      end
      default: ;
    endcase
  end

  // Advance the supervisor state once per processed transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      checkin_mask_r <= '0;
      record_valid_r <= 1'b0;
      boot_count_r   <= '0;
      wdt_count_r    <= '0;
      last_missing_r <= '0;
      stuck_mask_r   <= '0;
    end else if (step_en) begin
      checkin_mask_r <= checkin_mask_nxt;
      record_valid_r <= record_valid_nxt;
      boot_count_r   <= boot_count_nxt;
      wdt_count_r    <= wdt_count_nxt;
      last_missing_r <= last_missing_nxt;
      stuck_mask_r   <= stuck_mask_nxt;
    end
  end

  assign res.feed            = feed;
  assign res.missing_tasks   = last_missing_nxt;
  assign res.boot_total      = boot_count_nxt;
  assign res.watchdog_resets = wdt_count_nxt;
  assign res.stuck_tasks     = stuck_mask_nxt;

  // Counters move only on a processed boot
  a_boot_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !(step_en && (item.cmd == CMD_BOOT)) |=> $stable(boot_count_r))
    else $error("boot count changed outside a boot");

  a_wdt_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !(step_en && (item.cmd == CMD_BOOT)) |=> $stable(wdt_count_r))
    else $error("watchdog count changed outside a boot");

  // Record is valid after any boot
  a_valid_after_boot: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && (item.cmd == CMD_BOOT) |=> record_valid_r)
    else $error("record not valid after boot");

  // Feed only on a poll with nothing missing, and the round restarts
  a_feed_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res.feed |=> (checkin_mask_r == '0) && (last_missing_r == '0))
    else $error("feed without a clean round");

endmodule
